@@ design/lbcp_pkg.sv @@
// Shared types, constants and helpers for the line/box cross-and-project unit.
package lbcp_pkg;

    // Front-to-back queue
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Result buffer in the back end
    localparam int ODEPTH = 32;
    localparam int OAW    = $clog2(ODEPTH);
    localparam int OCW    = $clog2(ODEPTH + 1);

    // Pipelined divider: quotient bits per stage and stage count
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = 11;
    localparam int QW         = DIV_BITS * DIV_STAGES;

    // Quotient magnitude clamp (2^40)
    localparam logic [44:0] QCLAMP = 45'd1 << 40;

    // Axis codes
    typedef logic [1:0] axis_t;
    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CRYO_X  = 3'd0;
    localparam logic [2:0] CFG_CRYO_Y  = 3'd1;
    localparam logic [2:0] CFG_CRYO_Z  = 3'd2;
    localparam logic [2:0] CFG_WORLD_X = 3'd3;
    localparam logic [2:0] CFG_WORLD_Y = 3'd4;
    localparam logic [2:0] CFG_WORLD_Z = 3'd5;

    typedef struct packed {
        logic [2:0][63:0] cryo;
        logic [2:0][63:0] world;
    } cfg_t;

    // Classified particle handed from front to back
    typedef struct packed {
        logic [15:0]      tag;
        logic             hit;
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
        axis_t            c;
        logic [31:0]      wall;
    } job_t;

    typedef struct packed {
        logic [15:0]      tag;
        logic             hit;
        logic [2:0][31:0] res;
        logic             sat;
    } result_t;

    // The i-th axis other than a, in ascending order
    function automatic axis_t other_axis(axis_t a, logic i);
        axis_t r;
        unique case (a)
            AX_X:    r = i ? AX_Z : AX_Y;
            AX_Y:    r = i ? AX_Z : AX_X;
            default: r = i ? AX_Y : AX_X;
        endcase
        return r;
    endfunction

endpackage

@@ design/lbcp_front.sv @@
// Front end: face crossing test and nearest world wall selection.
module lbcp_front import lbcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [15:0] particle_tag,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] dir_x,
    input  logic [31:0] dir_y,
    input  logic [31:0] dir_z,
    input  cfg_t        cfg,
    output logic        job_valid,
    output job_t        job
);

    logic signed [31:0] pin [3];
    logic signed [31:0] vin [3];
    logic signed [31:0] clo [3];
    logic signed [31:0] chi [3];
    logic signed [31:0] wlo [3];
    logic signed [31:0] whi [3];

    // Stage 1: offsets and magnitudes
    logic                s1_vld_reg;
    logic [15:0]         s1_tag_reg;
    logic [2:0][31:0]    s1_p_reg;
    logic [2:0][31:0]    s1_v_reg;
    logic signed [32:0]  s1_dfc_reg [3][2];
    logic signed [32:0]  s1_dlo_reg [3];
    logic signed [32:0]  s1_dhi_reg [3];
    logic [31:0]         s1_m_reg   [3];
    logic signed [32:0]  s1_num_reg [3];
    logic [2:0]          s1_nz_reg;
    logic [2:0]          s1_neg_reg;
    logic [2:0][31:0]    s1_wall_reg;

    // Stage 2: products
    logic                s2_vld_reg;
    logic [15:0]         s2_tag_reg;
    logic [2:0][31:0]    s2_p_reg;
    logic [2:0][31:0]    s2_v_reg;
    logic signed [64:0]  s2_cr_reg [3][2][2];
    logic signed [65:0]  s2_ml_reg [3][2];
    logic signed [65:0]  s2_mh_reg [3][2];
    logic signed [65:0]  s2_wp10_reg, s2_wp01_reg, s2_wp20_reg;
    logic signed [65:0]  s2_wp02_reg, s2_wp21_reg, s2_wp12_reg;
    logic [2:0]          s2_nz_reg;
    logic [2:0]          s2_neg_reg;
    logic [2:0][31:0]    s2_wall_reg;

    // Stage 3: compares
    logic                s3_vld_reg;
    logic [15:0]         s3_tag_reg;
    logic [2:0][31:0]    s3_p_reg;
    logic [2:0][31:0]    s3_v_reg;
    logic                s3_hit_reg;
    logic                s3_lt10_reg, s3_lt20_reg, s3_lt21_reg;
    logic [2:0]          s3_nz_reg;
    logic [2:0][31:0]    s3_wall_reg;

    logic                hit_c;
    axis_t               c_sel;

    logic                job_vld_reg;
    job_t                job_reg;

    always_comb
    begin
        pin[0] = pos_x; pin[1] = pos_y; pin[2] = pos_z;
        vin[0] = dir_x; vin[1] = dir_y; vin[2] = dir_z;
        for (int k = 0; k < 3; k++)
        begin
            clo[k] = cfg.cryo[k][31:0];
            chi[k] = cfg.cryo[k][63:32];
            wlo[k] = cfg.world[k][31:0];
            whi[k] = cfg.world[k][63:32];
        end
    end

    // Valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            job_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= take;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            job_vld_reg <= s3_vld_reg;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= particle_tag;
        for (int a = 0; a < 3; a++)
        begin
            s1_p_reg[a] <= pin[a];
            s1_v_reg[a] <= vin[a];
            s1_dfc_reg[a][0] <= {clo[a][31], clo[a]} - {pin[a][31], pin[a]};
            s1_dfc_reg[a][1] <= {chi[a][31], chi[a]} - {pin[a][31], pin[a]};
            s1_dlo_reg[a] <= {pin[a][31], pin[a]} - {clo[a][31], clo[a]};
            s1_dhi_reg[a] <= {chi[a][31], chi[a]} - {pin[a][31], pin[a]};
            s1_m_reg[a]   <= vin[a][31] ? (~vin[a] + 32'd1) : vin[a];
            s1_num_reg[a] <= (vin[a][31] == 1'b0) ?
                             ({whi[a][31], whi[a]} - {pin[a][31], pin[a]}) :
                             ({pin[a][31], pin[a]} - {wlo[a][31], wlo[a]});
            s1_nz_reg[a]   <= (vin[a] != 32'sd0);
            s1_neg_reg[a]  <= vin[a][31];
            s1_wall_reg[a] <= vin[a][31] ? wlo[a] : whi[a];
        end
    end

    // Stage 2 payload: face cross products and step length cross products
    always_ff @(posedge clk)
    begin
        s2_tag_reg  <= s1_tag_reg;
        s2_p_reg    <= s1_p_reg;
        s2_v_reg    <= s1_v_reg;
        s2_nz_reg   <= s1_nz_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_wall_reg <= s1_wall_reg;
        for (int a = 0; a < 3; a++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    s2_cr_reg[a][s][i] <=
                        $signed(s1_v_reg[other_axis(2'(a), i[0])]) * s1_dfc_reg[a][s];
                end
                s2_ml_reg[a][i] <= s1_dlo_reg[other_axis(2'(a), i[0])] *
                                   $signed({1'b0, s1_m_reg[a]});
                s2_mh_reg[a][i] <= s1_dhi_reg[other_axis(2'(a), i[0])] *
                                   $signed({1'b0, s1_m_reg[a]});
            end
        end
        s2_wp10_reg <= s1_num_reg[1] * $signed({1'b0, s1_m_reg[0]});
        s2_wp01_reg <= s1_num_reg[0] * $signed({1'b0, s1_m_reg[1]});
        s2_wp20_reg <= s1_num_reg[2] * $signed({1'b0, s1_m_reg[0]});
        s2_wp02_reg <= s1_num_reg[0] * $signed({1'b0, s1_m_reg[2]});
        s2_wp21_reg <= s1_num_reg[2] * $signed({1'b0, s1_m_reg[1]});
        s2_wp12_reg <= s1_num_reg[1] * $signed({1'b0, s1_m_reg[2]});
    end

    // Face bound checks, all six faces in parallel
    always_comb
    begin
        logic               ok;
        logic signed [65:0] crs;
        logic signed [66:0] sum1;
        logic signed [66:0] sum2;
        hit_c = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                ok = s2_nz_reg[a];
                for (int i = 0; i < 2; i++)
                begin
                    crs  = {s2_cr_reg[a][s][i][64], s2_cr_reg[a][s][i]};
                    crs  = s2_neg_reg[a] ? -crs : crs;
                    sum1 = {s2_ml_reg[a][i][65], s2_ml_reg[a][i]} + {crs[65], crs};
                    sum2 = {s2_mh_reg[a][i][65], s2_mh_reg[a][i]} - {crs[65], crs};
                    if (sum1[66] || sum2[66])
                        ok = 1'b0;
                end
                hit_c = hit_c | ok;
            end
        end
    end

    // Stage 3 payload
    always_ff @(posedge clk)
    begin
        s3_tag_reg  <= s2_tag_reg;
        s3_p_reg    <= s2_p_reg;
        s3_v_reg    <= s2_v_reg;
        s3_nz_reg   <= s2_nz_reg;
        s3_wall_reg <= s2_wall_reg;
        s3_hit_reg  <= hit_c;
        s3_lt10_reg <= (s2_wp10_reg < s2_wp01_reg);
        s3_lt20_reg <= (s2_wp20_reg < s2_wp02_reg);
        s3_lt21_reg <= (s2_wp21_reg < s2_wp12_reg);
    end

    // Nearest wall: strict minimum, ties to the lower axis
    always_comb
    begin
        logic have;
        have  = 1'b0;
        c_sel = AX_X;
        if (s3_nz_reg[0])
            have = 1'b1;
        if (s3_nz_reg[1] && (!have || s3_lt10_reg))
        begin
            c_sel = AX_Y;
            have  = 1'b1;
        end
        if (s3_nz_reg[2] && (!have || ((c_sel == AX_X) ? s3_lt20_reg : s3_lt21_reg)))
            c_sel = AX_Z;
    end

    // Stage 4: job register
    always_ff @(posedge clk)
    begin
        job_reg.tag  <= s3_tag_reg;
        job_reg.hit  <= s3_hit_reg;
        job_reg.p    <= s3_p_reg;
        job_reg.v    <= s3_v_reg;
        job_reg.c    <= c_sel;
        job_reg.wall <= s3_wall_reg[c_sel];
    end

    assign job_valid = job_vld_reg;
    assign job       = job_reg;

endmodule

@@ design/lbcp_queue.sv @@
// Short FIFO between the classifying front end and the projecting back end.
module lbcp_queue import lbcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic nonempty,
    output job_t head_job
);

    job_t             mem [QDEPTH];
    logic [QAW-1:0]   wptr_reg;
    logic [QAW-1:0]   rptr_reg;
    logic [QCW-1:0]   count_reg;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_job;
    end

    assign nonempty = (count_reg != '0);
    assign head_job = mem[rptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == QCW'(QDEPTH))))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && (count_reg == '0)))
        else $error("queue read while empty");

endmodule

@@ design/lbcp_div_lane.sv @@
// Pipelined restoring divider lane: DIV_BITS quotient bits per stage.
module lbcp_div_lane import lbcp_pkg::*;
(
    input  logic          clk,
    input  logic [31:0]   rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [31:0]   d_in,
    output logic [QW-1:0] q_out,
    output logic [31:0]   r_out,
    output logic [31:0]   d_out
);

    logic [31:0]   rem_reg [DIV_STAGES];
    logic [QW-1:0] num_reg [DIV_STAGES];
    logic [QW-1:0] q_reg   [DIV_STAGES];
    logic [31:0]   d_reg   [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [31:0]   rin;
        logic [QW-1:0] nin;
        logic [QW-1:0] qin;
        logic [31:0]   din;
        logic [31:0]   rnx;
        logic [QW-1:0] nnx;
        logic [QW-1:0] qnx;

        if (s == 0)
        begin : g_first
            assign rin = rem_in;
            assign nin = num_in;
            assign qin = '0;
            assign din = d_in;
        end
        else
        begin : g_next
            assign rin = rem_reg[s-1];
            assign nin = num_reg[s-1];
            assign qin = q_reg[s-1];
            assign din = d_reg[s-1];
        end

        // Shift in a dividend bit, subtract when the divisor fits
        always_comb
        begin
            logic [32:0] t;
            rnx = rin;
            nnx = nin;
            qnx = qin;
            for (int i = 0; i < DIV_BITS; i++)
            begin
                t   = {rnx, nnx[QW-1]};
                nnx = {nnx[QW-2:0], 1'b0};
                if (t >= {1'b0, din})
                begin
                    t   = t - {1'b0, din};
                    qnx = {qnx[QW-2:0], 1'b1};
                end
                else
                begin
                    qnx = {qnx[QW-2:0], 1'b0};
                end
                rnx = t[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rnx;
            num_reg[s] <= nnx;
            q_reg[s]   <= qnx;
            d_reg[s]   <= din;
        end
    end

    assign q_out = q_reg[DIV_STAGES-1];
    assign r_out = rem_reg[DIV_STAGES-1];
    assign d_out = d_reg[DIV_STAGES-1];

endmodule

@@ design/lbcp_back.sv @@
// Back end: projection of crossing particles onto the chosen world wall.
module lbcp_back import lbcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_nonempty,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tag_out,
    output logic        crosses_box,
    output logic [31:0] proj_x,
    output logic [31:0] proj_y,
    output logic [31:0] proj_z,
    output logic        saturated
);

    typedef struct packed {
        logic [15:0]      tag;
        logic             hit;
        axis_t            c;
        logic [31:0]      wall;
        logic [1:0][31:0] pj;
        logic [1:0]       neg;
        logic [1:0]       clamp;
    } side_t;

    logic [OCW-1:0] bcnt_reg;
    logic [OCW-1:0] ocnt_reg;
    logic [OAW-1:0] wptr_reg;
    logic [OAW-1:0] rptr_reg;
    result_t        ofifo [ODEPTH];
    logic           out_take;

    // B1: wall offset, divisor, lane operands
    logic               b1_vld_reg;
    logic [15:0]        b1_tag_reg;
    logic               b1_hit_reg;
    axis_t              b1_c_reg;
    logic [31:0]        b1_wall_reg;
    logic signed [32:0] b1_dw_reg;
    logic [31:0]        b1_d_reg;
    logic               b1_negc_reg;
    logic [1:0][31:0]   b1_pj_reg;
    logic [1:0][31:0]   b1_vj_reg;

    // B2: numerators
    logic               b2_vld_reg;
    logic [15:0]        b2_tag_reg;
    logic               b2_hit_reg;
    axis_t              b2_c_reg;
    logic [31:0]        b2_wall_reg;
    logic [31:0]        b2_d_reg;
    logic               b2_negc_reg;
    logic [1:0][31:0]   b2_pj_reg;
    logic signed [64:0] b2_n_reg [2];

    // B3: magnitudes, split dividend
    logic               b3_vld_reg;
    side_t              b3_side_reg;
    logic [31:0]        b3_d_reg;
    logic [31:0]        b3_rem_reg [2];
    logic [QW-1:0]      b3_num_reg [2];

    // Divider sideband
    logic               sd_vld_reg  [DIV_STAGES];
    side_t              sd_side_reg [DIV_STAGES];

    logic [QW-1:0]      lq [2];
    logic [31:0]        lr [2];
    logic [31:0]        ld [2];

    // R1: rounded, clamped quotient magnitudes
    logic               r1_vld_reg;
    side_t              r1_side_reg;
    logic [40:0]        r1_qm_reg [2];

    result_t            res_c;

    assign q_pop    = q_nonempty && (bcnt_reg < OCW'(ODEPTH));
    assign out_take = out_valid && out_ready;

    // Control: valid chain, credit count, result buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++)
                sd_vld_reg[s] <= 1'b0;
            r1_vld_reg <= 1'b0;
            bcnt_reg   <= '0;
            ocnt_reg   <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
        end
        else
        begin
            b1_vld_reg    <= q_pop;
            b2_vld_reg    <= b1_vld_reg;
            b3_vld_reg    <= b2_vld_reg;
            sd_vld_reg[0] <= b3_vld_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                sd_vld_reg[s] <= sd_vld_reg[s-1];
            r1_vld_reg <= sd_vld_reg[DIV_STAGES-1];
            bcnt_reg   <= bcnt_reg + OCW'(q_pop) - OCW'(out_take);
            ocnt_reg   <= ocnt_reg + OCW'(r1_vld_reg) - OCW'(out_take);
            if (r1_vld_reg)
                wptr_reg <= wptr_reg + 1'b1;
            if (out_take)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    // B1 payload
    always_ff @(posedge clk)
    begin
        b1_tag_reg  <= q_job.tag;
        b1_hit_reg  <= q_job.hit;
        b1_c_reg    <= q_job.c;
        b1_wall_reg <= q_job.wall;
        b1_dw_reg   <= {q_job.wall[31], q_job.wall} -
                       {q_job.p[q_job.c][31], q_job.p[q_job.c]};
        b1_d_reg    <= q_job.v[q_job.c][31] ? (~q_job.v[q_job.c] + 32'd1) :
                                              q_job.v[q_job.c];
        b1_negc_reg <= q_job.v[q_job.c][31];
        for (int i = 0; i < 2; i++)
        begin
            b1_pj_reg[i] <= q_job.p[other_axis(q_job.c, i[0])];
            b1_vj_reg[i] <= q_job.v[other_axis(q_job.c, i[0])];
        end
    end

    // B2 payload
    always_ff @(posedge clk)
    begin
        b2_tag_reg  <= b1_tag_reg;
        b2_hit_reg  <= b1_hit_reg;
        b2_c_reg    <= b1_c_reg;
        b2_wall_reg <= b1_wall_reg;
        b2_d_reg    <= b1_d_reg;
        b2_negc_reg <= b1_negc_reg;
        b2_pj_reg   <= b1_pj_reg;
        for (int i = 0; i < 2; i++)
            b2_n_reg[i] <= $signed(b1_vj_reg[i]) * b1_dw_reg;
    end

    // B3 payload: sign, magnitude, top-part overflow check
    always_ff @(posedge clk)
    begin
        logic [64:0] mag;
        b3_side_reg.tag  <= b2_tag_reg;
        b3_side_reg.hit  <= b2_hit_reg;
        b3_side_reg.c    <= b2_c_reg;
        b3_side_reg.wall <= b2_wall_reg;
        b3_side_reg.pj   <= b2_pj_reg;
        b3_d_reg         <= b2_d_reg;
        for (int i = 0; i < 2; i++)
        begin
            mag = b2_n_reg[i][64] ? (~b2_n_reg[i] + 65'd1) : b2_n_reg[i];
            b3_side_reg.neg[i]   <= b2_n_reg[i][64] ^ b2_negc_reg;
            b3_side_reg.clamp[i] <= ({11'd0, mag[64:QW]} >= b2_d_reg);
            b3_rem_reg[i]        <= {11'd0, mag[64:QW]};
            b3_num_reg[i]        <= mag[QW-1:0];
        end
    end

    // Two divider lanes
    for (genvar g = 0; g < 2; g++)
    begin : g_lane
        lbcp_div_lane u_lane (
            .clk    (clk),
            .rem_in (b3_rem_reg[g]),
            .num_in (b3_num_reg[g]),
            .d_in   (b3_d_reg),
            .q_out  (lq[g]),
            .r_out  (lr[g]),
            .d_out  (ld[g])
        );
    end

    // Sideband alongside the divider
    always_ff @(posedge clk)
    begin
        sd_side_reg[0] <= b3_side_reg;
        for (int s = 1; s < DIV_STAGES; s++)
            sd_side_reg[s] <= sd_side_reg[s-1];
    end

    // R1: round half away from zero, then clamp
    always_ff @(posedge clk)
    begin
        logic [44:0] qr;
        r1_side_reg <= sd_side_reg[DIV_STAGES-1];
        for (int i = 0; i < 2; i++)
        begin
            qr = {1'b0, lq[i]} + 45'(lr[i] >= (ld[i] - lr[i]));
            if (sd_side_reg[DIV_STAGES-1].clamp[i] || (qr > QCLAMP))
                r1_qm_reg[i] <= QCLAMP[40:0];
            else
                r1_qm_reg[i] <= qr[40:0];
        end
    end

    // Final sum with saturation, placed by axis
    always_comb
    begin
        logic [41:0] sum;
        logic [31:0] lane_res [2];
        logic        sat;
        sat = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            if (r1_side_reg.neg[i])
                sum = {{10{r1_side_reg.pj[i][31]}}, r1_side_reg.pj[i]} - {1'b0, r1_qm_reg[i]};
            else
                sum = {{10{r1_side_reg.pj[i][31]}}, r1_side_reg.pj[i]} + {1'b0, r1_qm_reg[i]};
            if ((sum[41:31] != 11'h000) && (sum[41:31] != 11'h7FF))
            begin
                sat         = 1'b1;
                lane_res[i] = sum[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                lane_res[i] = sum[31:0];
            end
        end
        res_c.tag = r1_side_reg.tag;
        res_c.hit = r1_side_reg.hit;
        res_c.res = '0;
        res_c.sat = 1'b0;
        if (r1_side_reg.hit)
        begin
            res_c.res[r1_side_reg.c]                   = r1_side_reg.wall;
            res_c.res[other_axis(r1_side_reg.c, 1'b0)] = lane_res[0];
            res_c.res[other_axis(r1_side_reg.c, 1'b1)] = lane_res[1];
            res_c.sat                                  = sat;
        end
    end

    // Result buffer
    always_ff @(posedge clk)
    begin
        if (r1_vld_reg)
            ofifo[wptr_reg] <= res_c;
    end

    assign out_valid   = (ocnt_reg != '0);
    assign tag_out     = ofifo[rptr_reg].tag;
    assign crosses_box = ofifo[rptr_reg].hit;
    assign proj_x      = ofifo[rptr_reg].res[0];
    assign proj_y      = ofifo[rptr_reg].res[1];
    assign proj_z      = ofifo[rptr_reg].res[2];
    assign saturated   = ofifo[rptr_reg].sat;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bcnt_reg <= OCW'(ODEPTH)) && (ocnt_reg <= bcnt_reg))
        else $error("back end credit count out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !crosses_box) |->
        ((proj_x == 32'd0) && (proj_y == 32'd0) && (proj_z == 32'd0) && !saturated))
        else $error("non-crossing result carries projection data");

endmodule

@@ design/line_box_cross_and_project_unit.sv @@
// Top level of the line/box cross-and-project unit: config registers and glue.
// Path to result valid: the first front stage loads on the accepting edge, then
//   3 front stages, queue write, 3 back stages, 11 divider stages, round, buffer write;
//   the result buffer then offers the result transaction.
// Throughput: one particle per cycle unless credits run out; divider lanes are pipelined.
// Reset: counters and valids clear at once; all config registers read 0.
module line_box_cross_and_project_unit import lbcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] particle_tag,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] dir_x,
    input  logic [31:0] dir_y,
    input  logic [31:0] dir_z,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tag_out,
    output logic        crosses_box,
    output logic [31:0] proj_x,
    output logic [31:0] proj_y,
    output logic [31:0] proj_z,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    cfg_t            cfg_reg;
    logic [QCW-1:0]  fcnt_reg;
    logic            take;
    logic            job_valid;
    job_t            job;
    logic            q_nonempty;
    job_t            q_job;
    logic            q_pop;

    assign cfg_ready = 1'b1;
    assign in_ready  = (fcnt_reg < QCW'(QDEPTH));
    assign take      = in_valid && in_ready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CRYO_X:  cfg_reg.cryo[0]  <= cfg_data;
                CFG_CRYO_Y:  cfg_reg.cryo[1]  <= cfg_data;
                CFG_CRYO_Z:  cfg_reg.cryo[2]  <= cfg_data;
                CFG_WORLD_X: cfg_reg.world[0] <= cfg_data;
                CFG_WORLD_Y: cfg_reg.world[1] <= cfg_data;
                CFG_WORLD_Z: cfg_reg.world[2] <= cfg_data;
                default:     cfg_reg          <= cfg_reg;
            endcase
        end
    end

    // Front credits: items in the front pipeline plus queue entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fcnt_reg <= '0;
        else
            fcnt_reg <= fcnt_reg + QCW'(take) - QCW'(q_pop);
    end

    lbcp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .particle_tag (particle_tag),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .cfg          (cfg_reg),
        .job_valid    (job_valid),
        .job          (job)
    );

    lbcp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head_job (q_job)
    );

    lbcp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tag_out     (tag_out),
        .crosses_box (crosses_box),
        .proj_x      (proj_x),
        .proj_y      (proj_y),
        .proj_z      (proj_z),
        .saturated   (saturated)
    );

    a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= QCW'(QDEPTH))
        else $error("front credit count above queue depth");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the line/box cross-and-project unit: predictor, scoreboard, stimulus.
module tb_top;
    import lbcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected projection of one particle
    typedef struct {
        logic [15:0] tag;
        logic        hit;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        sat;
    } proj_t;

    // Box and wall settings mirrored from the configuration writes
    logic [63:0] cryo_mirror [3];
    logic [63:0] world_mirror [3];

    // Crossing test against one face of the detector box
    function automatic bit face_crossed(logic signed [63:0] p [3], logic signed [63:0] v [3],
                                        int a, logic signed [63:0] b,
                                        logic signed [63:0] lo [3], logic signed [63:0] hi [3]);
        logic signed [127:0] m, crs, t;
        if (v[a] == 0)
            return 0;
        m = v[a] < 0 ? -v[a] : v[a];
        for (int k = 0; k < 3; k++)
        begin
            if (k == a)
                continue;
            crs = 128'(v[k]) * 128'(b - p[a]);
            if (v[a] < 0)
                crs = -crs;
            t = 128'(p[k] - lo[k]) * m + crs;
            if (t < 0)
                return 0;
            t = 128'(hi[k] - p[k]) * m - crs;
            if (t < 0)
                return 0;
        end
        return 1;
    endfunction

    // Crossing flag and world-edge projection of one particle
    function automatic proj_t project_particle(logic [15:0] tag, logic [31:0] pin [3],
                                               logic [31:0] vin [3]);
        proj_t r;
        logic signed [63:0] p [3], v [3], clo [3], chi [3], wlo [3], whi [3];
        logic signed [63:0] num [3], den [3], wall, s;
        logic signed [127:0] n, lhs, rhs;
        logic [127:0] nm, q, rm, d, qm;
        bit neg;
        int c;
        c = -1;
        for (int a = 0; a < 3; a++)
        begin
            p[a] = 64'(signed'(pin[a]));
            v[a] = 64'(signed'(vin[a]));
            clo[a] = 64'(signed'(cryo_mirror[a][31:0]));
            chi[a] = 64'(signed'(cryo_mirror[a][63:32]));
            wlo[a] = 64'(signed'(world_mirror[a][31:0]));
            whi[a] = 64'(signed'(world_mirror[a][63:32]));
        end
        r = '{tag, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
        for (int f = 0; f < 6 && !r.hit; f++)
            r.hit = face_crossed(p, v, f >> 1, (f & 1) ? chi[f >> 1] : clo[f >> 1], clo, chi);
        if (!r.hit)
            return r;
        for (int a = 0; a < 3; a++)
        begin
            if (v[a] == 0)
                continue;
            if (v[a] > 0)
            begin
                num[a] = whi[a] - p[a];
                den[a] = v[a];
            end
            else
            begin
                num[a] = p[a] - wlo[a];
                den[a] = -v[a];
            end
            if (c < 0)
                c = a;
            else
            begin
                lhs = 128'(num[a]) * 128'(den[c]);
                rhs = 128'(num[c]) * 128'(den[a]);
                if (lhs < rhs)
                    c = a;
            end
        end
        wall = v[c] > 0 ? whi[c] : wlo[c];
        for (int a = 0; a < 3; a++)
        begin
            if (a == c)
                s = wall;
            else
            begin
                n = 128'(v[a]) * 128'(wall - p[c]);
                neg = (n < 0) != (v[c] < 0);
                nm = n < 0 ? -n : n;
                d = v[c] < 0 ? -v[c] : v[c];
                q = nm / d;
                rm = nm % d;
                if (rm >= d - rm)
                    q = q + 1;
                qm = q > (128'd1 << 40) ? (128'd1 << 40) : q;
                s = neg ? p[a] - 64'(qm) : p[a] + 64'(qm);
                if (s > 64'sh7FFFFFFF)
                begin
                    s = 64'sh7FFFFFFF;
                    r.sat = 1;
                end
                else if (s < -64'sh80000000)
                begin
                    s = -64'sh80000000;
                    r.sat = 1;
                end
            end
            if (a == 0) r.px = s[31:0];
            else if (a == 1) r.py = s[31:0];
            else r.pz = s[31:0];
        end
        return r;
    endfunction

    // Queue of expected projections, checked in order
    class proj_scoreboard;
        proj_t pending [$];
        int errors;

        function void note_particle(proj_t e);
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(proj_t got);
            proj_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction, tag %0h", got.tag);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tag !== e.tag)
            begin
                $error("tag_out expected %0h actual %0h", e.tag, got.tag);
                errors++;
            end
            if (got.hit !== e.hit)
            begin
                $error("crosses_box expected %0b actual %0b", e.hit, got.hit);
                errors++;
            end
            if (got.px !== e.px)
            begin
                $error("proj_x expected %0h actual %0h", e.px, got.px);
                errors++;
            end
            if (got.py !== e.py)
            begin
                $error("proj_y expected %0h actual %0h", e.py, got.py);
                errors++;
            end
            if (got.pz !== e.pz)
            begin
                $error("proj_z expected %0h actual %0h", e.pz, got.pz);
                errors++;
            end
            if (got.sat !== e.sat)
            begin
                $error("saturated expected %0b actual %0b", e.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
    logic [15:0] particle_tag, tag_out;
    logic [31:0] pos_x, pos_y, pos_z, dir_x, dir_y, dir_z;
    logic        crosses_box, saturated;
    logic [31:0] proj_x, proj_y, proj_z;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    proj_scoreboard sb = new();
    bit             hold_off;
    bit             stim_done;

    line_box_cross_and_project_unit i_dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Write one configuration register and mirror it
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < CFG_WORLD_X)
            cryo_mirror[idx] = val;
        else
            world_mirror[idx - CFG_WORLD_X] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pack_range(int lo, int hi);
        return {32'(hi), 32'(lo)};
    endfunction

    // Detector box and world settings; mode 0 sane, 1 extreme, 2 random
    task automatic set_geometry(int mode);
        logic [31:0] a, b;
        for (int i = 0; i < 6; i++)
        begin
            if (mode == 0)
                write_reg(3'(i), i < 3 ? pack_range(-25600, 25600) : pack_range(-256000, 256000));
            else if (mode == 1)
                write_reg(3'(i), i[0] ? 64'hFFFF_FFFF_FFFF_FFFF : {32'h7FFF_FFFF, 32'h8000_0000});
            else
            begin
                a = $urandom_range(0, 60000) - 30000;
                b = a + $urandom_range(0, 60000) - (($urandom_range(0, 9) == 0) ? 70000 : 0);
                if ($urandom_range(0, 4) == 0)
                    write_reg(3'(i), {$urandom, $urandom});
                else
                    write_reg(3'(i), i < 3 ? {b, a} : {b << 4, a << 4});
            end
        end
    endtask

    // Offer one particle and record its expected projection; valid stays up after
    // the transaction so that a zero gap gives back-to-back transactions
    task automatic send_particle(logic [31:0] pv [3], logic [31:0] dv [3]);
        logic [15:0] tag;
        int idle;
        tag = 16'($urandom);
        idle = $urandom_range(0, 10);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid     <= 1'b1;
        particle_tag <= tag;
        pos_x <= pv[0];
        pos_y <= pv[1];
        pos_z <= pv[2];
        dir_x <= dv[0];
        dir_y <= dv[1];
        dir_z <= dv[2];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_particle(project_particle(tag, pv, dv));
        @(negedge clk);
    endtask

    // Random particle: mostly bounded positions and directions, sometimes raw bits
    task automatic send_random;
        logic [31:0] pv [3], dv [3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++)
        begin
            if (kind == 0)
            begin
                pv[a] = $urandom;
                dv[a] = $urandom;
            end
            else
            begin
                pv[a] = $urandom_range(0, 200000) - 100000;
                dv[a] = $urandom_range(0, 131072) - 65536;
                if ($urandom_range(0, 7) == 0)
                    dv[a] = 0;
                if (kind == 1)
                    dv[a] = dv[a] << 14;
            end
        end
        send_particle(pv, dv);
    endtask

    // Drop input valid, then wait for every expected result
    task automatic wait_drained;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Result side: random stalls and a long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result('{tag_out, crosses_box, proj_x, proj_y, proj_z, saturated});

    // Stimulus
    initial
    begin
        logic [31:0] pv [3], dv [3];
        in_valid = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        particle_tag = '0; pos_x = '0; pos_y = '0; pos_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        hold_off = 0; stim_done = 0;
        for (int i = 0; i < 3; i++)
        begin
            cryo_mirror[i] = '0;
            world_mirror[i] = '0;
        end
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset geometry, then a sane box
        pv = '{0, 0, 0}; dv = '{0, 0, 0};
        send_particle(pv, dv);
        wait_drained();
        set_geometry(0);
        pv = '{0, 0, 0}; dv = '{0, 0, 0};
        send_particle(pv, dv);
        pv = '{0, 0, 0}; dv = '{0, 32'h10000, 0};
        send_particle(pv, dv);
        pv = '{0, 0, 0}; dv = '{32'h10000, 32'h10000, 32'h10000};
        send_particle(pv, dv);
        pv = '{0, 0, 0}; dv = '{32'hFFFF0000, 32'hFFFF0000, 0};
        send_particle(pv, dv);
        pv = '{25600, 25600, 25600}; dv = '{0, 0, 32'h10000};
        send_particle(pv, dv);
        pv = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        dv = '{32'h7FFFFFFF, 32'h80000000, 32'h00000001};
        send_particle(pv, dv);
        pv = '{0, 0, 0}; dv = '{1, 32'h7FFFFFFF, 32'h80000000};
        send_particle(pv, dv);
        pv = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        dv = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        send_particle(pv, dv);
        pv = '{300000, 0, 0}; dv = '{32'hFFFF0000, 0, 0};
        send_particle(pv, dv);
        wait_drained();
        set_geometry(1);
        pv = '{0, 0, 0}; dv = '{32'h10000, 3, 32'h80000000};
        send_particle(pv, dv);
        pv = '{32'h80000000, 32'h7FFFFFFF, 0}; dv = '{1, 32'hFFFFFFFF, 32'h7FFFFFFF};
        send_particle(pv, dv);
        wait_drained();

        // Random phases with changing geometry; one long result stall
        for (int ph = 0; ph < 11; ph++)
        begin
            set_geometry(ph == 0 ? 0 : 2);
            for (int n = 0; n < 150; n++)
            begin
                if (ph == 3 && n == 10)
                    hold_off = 1;
                send_random();
            end
            wait_drained();
        end
        stim_done = 1;
    end

    // Long hold-off counted in its own process
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            repeat (300) @(posedge clk);
            hold_off = 0;
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
